/* hw/rtl/pdtc_pkg.sv */
// pdtc_pkg: types, constants and helper functions for the pwm duty to timer counts block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pdtc_pkg;

  localparam int unsigned MAX_RESOLUTION_BITS = 16;
  localparam int unsigned FULL_W   = MAX_RESOLUTION_BITS;
  localparam int unsigned CLK_W    = 32;
  localparam int unsigned FREQ_W   = 17;
  localparam int unsigned RES_W    = 5;
  localparam int unsigned TOTAL_W  = CLK_W - 2;
  localparam int unsigned PROD_W   = TOTAL_W + FULL_W;
  localparam int unsigned DQ_W     = 48;
  localparam int unsigned REM_W    = FREQ_W;
  localparam int unsigned DIV1_STEPS = TOTAL_W;
  localparam int unsigned DIV2_STEPS = PROD_W;
  localparam int unsigned NCELL    = DIV1_STEPS + DIV2_STEPS;
  localparam int unsigned NLINK    = NCELL + 2;

  localparam logic [CLK_W-1:0]  RESET_CLOCK_HZ = 32'd204000000;
  localparam logic [FREQ_W-1:0] RESET_FREQ_HZ  = 17'd1000;
  localparam logic [RES_W-1:0]  RESET_RES_BITS = 5'd8;
  localparam logic [FREQ_W-1:0] MAX_FREQ_HZ    = 17'd100000;

  typedef enum logic [1:0] {
    REG_CORE_CLOCK = 2'd0,
    REG_PWM_FREQ   = 2'd1,
    REG_RES_BITS   = 2'd2,
    REG_UNUSED     = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_LOW  = 2'd1,
    ACT_HIGH = 2'd2,
    ACT_PWM  = 2'd3
  } action_t;

  typedef struct packed {
    action_t            act;
    logic [2:0]         ch;
    logic [FULL_W-1:0]  duty;
    logic [TOTAL_W-1:0] total;
    logic [REM_W-1:0]   rem;
    logic [DQ_W-1:0]    dq;
  } pipe_t;

  typedef struct packed {
    logic       pwm;
    logic [2:0] ch;
  } chan_t;

  function automatic chan_t channel_of_pin(input logic [7:0] pin);
    chan_t c;
    c.pwm = 1'b1;
    c.ch  = 3'd0;
    unique case (pin)
      8'h10:   c.ch = 3'd0;
      8'h11:   c.ch = 3'd1;
      8'h02:   c.ch = 3'd2;
      8'h03:   c.ch = 3'd3;
      8'h26:   c.ch = 3'd4;
      8'h27:   c.ch = 3'd5;
      default: c.pwm = 1'b0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/pdtc_if.sv */
// pdtc channel interfaces: input beat, result beat and register write beat
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface pdtc_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  pin_number;
  logic signed [31:0] duty_value;
  modport source (output valid, pin_number, duty_value, input ready);
  modport sink   (input valid, pin_number, duty_value, output ready);
endinterface

interface pdtc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [2:0]  channel;
  logic [31:0] high_reload;
  logic [31:0] low_reload;
  modport source (output valid, action, channel, high_reload, low_reload, input ready);
  modport sink   (input valid, action, channel, high_reload, low_reload, output ready);
endinterface

interface pdtc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/pdtc_div_cell.sv */
// pdtc_div_cell: one restoring division step with its own pipeline register
// depends on pdtc_pkg
`timescale 1ns / 1ps
`default_nettype none

module pdtc_div_cell (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic [pdtc_pkg::REM_W-1:0]   divisor,
  input  wire logic                         up_valid,
  input  wire pdtc_pkg::pipe_t              up_data,
  output logic                              up_ready,
  output logic                              dn_valid,
  output pdtc_pkg::pipe_t                   dn_data,
  input  wire logic                         dn_ready
);

  logic            valid_r;
  pdtc_pkg::pipe_t data_r;
  pdtc_pkg::pipe_t data_nxt;
  logic [pdtc_pkg::REM_W:0] sh;
  logic                     ge;

  always_comb begin
    sh       = {up_data.rem, up_data.dq[pdtc_pkg::DQ_W-1]};
    ge       = (sh >= {1'b0, divisor});
    data_nxt = up_data;
    data_nxt.rem = ge ? pdtc_pkg::REM_W'(sh - {1'b0, divisor}) : sh[pdtc_pkg::REM_W-1:0];
    data_nxt.dq  = {up_data.dq[pdtc_pkg::DQ_W-2:0], ge};
  end

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      data_r <= data_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/pwm_duty_to_timer_counts.sv */
// pwm_duty_to_timer_counts: pin decode, clamp and two chained division pipelines
// depends on pdtc_pkg, pdtc_if, pdtc_div_cell
`timescale 1ns / 1ps
`default_nettype none

// One beat in, one beat out, a new item every clock cycle while the output is not
// stalled. Each item passes a decode register, a row of 30 divider cells (timer
// clock / frequency), a multiply register, a row of 46 divider cells (product /
// full scale) and the output register. Each cell holds its item until the next
// one frees, so the row fills and drains under back-pressure.
// Register writes are always accepted and must only be made while idle.

module pwm_duty_to_timer_counts (
  input  wire logic  clk,
  input  wire logic  rst_n,
  pdtc_in_if.sink    in_ch,
  pdtc_out_if.source out_ch,
  pdtc_cfg_if.sink   cfg_ch
);

  logic [pdtc_pkg::CLK_W-1:0]  clock_r;
  logic [pdtc_pkg::FREQ_W-1:0] freq_r;
  logic [pdtc_pkg::RES_W-1:0]  res_r;
  logic [pdtc_pkg::FULL_W-1:0] full;

  logic [pdtc_pkg::FREQ_W-1:0] cfg_freq;
  logic [pdtc_pkg::RES_W-1:0]  cfg_res;

  assign cfg_ch.ready = 1'b1;
  assign cfg_freq = cfg_ch.data[pdtc_pkg::FREQ_W-1:0];
  assign cfg_res  = cfg_ch.data[pdtc_pkg::RES_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_r <= pdtc_pkg::RESET_CLOCK_HZ;
      freq_r  <= pdtc_pkg::RESET_FREQ_HZ;
      res_r   <= pdtc_pkg::RESET_RES_BITS;
    end else if (cfg_ch.valid) begin
      unique case (pdtc_pkg::reg_idx_t'(cfg_ch.index))
        pdtc_pkg::REG_CORE_CLOCK: clock_r <= cfg_ch.data;
        pdtc_pkg::REG_PWM_FREQ: begin
          if (cfg_freq != '0 && cfg_freq <= pdtc_pkg::MAX_FREQ_HZ) freq_r <= cfg_freq;
        end
        pdtc_pkg::REG_RES_BITS: begin
          if (cfg_res != '0 && cfg_res <= pdtc_pkg::RES_W'(pdtc_pkg::MAX_RESOLUTION_BITS))
            res_r <= cfg_res;
        end
        default: ;
      endcase
    end
  end

  assign full = pdtc_pkg::FULL_W'((17'd1 << res_r) - 17'd1);

  // links between stages
  logic            lk_valid [pdtc_pkg::NLINK];
  logic            lk_ready [pdtc_pkg::NLINK];
  pdtc_pkg::pipe_t lk_data  [pdtc_pkg::NLINK];

  // decode stage
  pdtc_pkg::chan_t cinfo;
  pdtc_pkg::pipe_t dec_nxt;
  logic            neg;
  logic [31:0]     raw;

  always_comb begin
    cinfo   = pdtc_pkg::channel_of_pin(in_ch.pin_number);
    raw     = in_ch.duty_value;
    neg     = raw[31];
    dec_nxt = '0;
    dec_nxt.act = pdtc_pkg::ACT_NONE;
    dec_nxt.dq  = {clock_r[pdtc_pkg::CLK_W-1:2], (pdtc_pkg::DQ_W - pdtc_pkg::TOTAL_W)'(0)};
    if (!cinfo.pwm) begin
      if (raw == '0) dec_nxt.act = pdtc_pkg::ACT_LOW;
      else if (!neg && raw >= 32'(full)) dec_nxt.act = pdtc_pkg::ACT_HIGH;
    end else begin
      dec_nxt.ch = cinfo.ch;
      if (neg || raw == '0) dec_nxt.act = pdtc_pkg::ACT_LOW;
      else if (raw >= 32'(full)) dec_nxt.act = pdtc_pkg::ACT_HIGH;
      else begin
        dec_nxt.act  = pdtc_pkg::ACT_PWM;
        dec_nxt.duty = raw[pdtc_pkg::FULL_W-1:0];
      end
    end
  end

  logic            dec_valid_r;
  pdtc_pkg::pipe_t dec_r;

  assign in_ch.ready = !dec_valid_r || lk_ready[0];
  assign lk_valid[0] = dec_valid_r;
  assign lk_data[0]  = dec_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dec_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      dec_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready) begin
      dec_r <= dec_nxt;
    end
  end

  // total / frequency row
  for (genvar k = 0; k < pdtc_pkg::DIV1_STEPS; k++) begin : g_div1
    pdtc_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .divisor  (freq_r),
      .up_valid (lk_valid[k]),
      .up_data  (lk_data[k]),
      .up_ready (lk_ready[k]),
      .dn_valid (lk_valid[k+1]),
      .dn_data  (lk_data[k+1]),
      .dn_ready (lk_ready[k+1])
    );
  end

  // multiply stage
  localparam int unsigned MI = pdtc_pkg::DIV1_STEPS;
  logic            mul_valid_r;
  pdtc_pkg::pipe_t mul_r;
  pdtc_pkg::pipe_t mul_nxt;
  logic [pdtc_pkg::TOTAL_W-1:0] tot;
  logic [pdtc_pkg::PROD_W-1:0]  prod;

  always_comb begin
    tot  = lk_data[MI].dq[pdtc_pkg::TOTAL_W-1:0];
    prod = pdtc_pkg::PROD_W'(tot) * pdtc_pkg::PROD_W'(lk_data[MI].duty);
    mul_nxt       = lk_data[MI];
    mul_nxt.total = tot;
    mul_nxt.rem   = '0;
    mul_nxt.dq    = {prod, (pdtc_pkg::DQ_W - pdtc_pkg::PROD_W)'(0)};
  end

  assign lk_ready[MI]   = !mul_valid_r || lk_ready[MI+1];
  assign lk_valid[MI+1] = mul_valid_r;
  assign lk_data[MI+1]  = mul_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_valid_r <= 1'b0;
    end else if (lk_ready[MI]) begin
      mul_valid_r <= lk_valid[MI];
    end
  end

  always_ff @(posedge clk) begin
    if (lk_ready[MI]) begin
      mul_r <= mul_nxt;
    end
  end

  // product / full scale row
  for (genvar k = 0; k < pdtc_pkg::DIV2_STEPS; k++) begin : g_div2
    pdtc_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .divisor  ({1'b0, full}),
      .up_valid (lk_valid[MI+1+k]),
      .up_data  (lk_data[MI+1+k]),
      .up_ready (lk_ready[MI+1+k]),
      .dn_valid (lk_valid[MI+2+k]),
      .dn_data  (lk_data[MI+2+k]),
      .dn_ready (lk_ready[MI+2+k])
    );
  end

  // output stage
  localparam int unsigned LI = pdtc_pkg::NLINK - 1;
  logic [pdtc_pkg::TOTAL_W-1:0] hi_raw;
  logic [pdtc_pkg::TOTAL_W-1:0] lo_raw;
  logic [pdtc_pkg::TOTAL_W-1:0] hi;
  logic [pdtc_pkg::TOTAL_W-1:0] lo;
  logic [31:0] hi_rel_nxt;
  logic [31:0] lo_rel_nxt;

  always_comb begin
    hi_raw = lk_data[LI].dq[pdtc_pkg::TOTAL_W-1:0];
    lo_raw = lk_data[LI].total - hi_raw;
    hi     = (hi_raw == '0) ? pdtc_pkg::TOTAL_W'(1) : hi_raw;
    lo     = (lo_raw == '0) ? pdtc_pkg::TOTAL_W'(1) : lo_raw;
    hi_rel_nxt = '0;
    lo_rel_nxt = '0;
    if (lk_data[LI].act == pdtc_pkg::ACT_PWM) begin
      hi_rel_nxt = 32'(hi - pdtc_pkg::TOTAL_W'(1));
      lo_rel_nxt = 32'(lo - pdtc_pkg::TOTAL_W'(1));
    end
  end

  logic        out_valid_r;
  logic [1:0]  act_r;
  logic [2:0]  ch_r;
  logic [31:0] hi_rel_r;
  logic [31:0] lo_rel_r;

  assign lk_ready[LI] = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (lk_ready[LI]) begin
      out_valid_r <= lk_valid[LI];
    end
  end

  always_ff @(posedge clk) begin
    if (lk_ready[LI]) begin
      act_r    <= lk_data[LI].act;
      ch_r     <= lk_data[LI].ch;
      hi_rel_r <= hi_rel_nxt;
      lo_rel_r <= lo_rel_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.action      = act_r;
  assign out_ch.channel     = ch_r;
  assign out_ch.high_reload = hi_rel_r;
  assign out_ch.low_reload  = lo_rel_r;

endmodule

`default_nettype wire
